// ----- design/lru_cache_byte_and_count_budget_unit_macros.svh -----
// Assertion macros for the LRU cache budget unit.
`ifndef LRU_CACHE_BYTE_AND_COUNT_BUDGET_UNIT_MACROS_SVH
`define LRU_CACHE_BYTE_AND_COUNT_BUDGET_UNIT_MACROS_SVH

// Same-cycle implication.
`define LCB_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcb check failed");

// Next-cycle implication.
`define LCB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcb check failed");

`endif

// ----- design/lcb_pkg.sv -----
package lcb_pkg;

    localparam int TAG_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int SIZE_W   = 32;
    localparam int BYTES_W  = 40;
    localparam int ENTRY_W  = 5;
    localparam int SERIAL_W = 64;
    localparam int STATUS_W = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_BUDGET = 1'b1;

    localparam logic [BYTES_W-1:0] BYTE_BUDGET_RST  = '1;
    localparam logic [ENTRY_W-1:0] ENTRY_BUDGET_RST = 5'd16;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_PRUNE  = 2'd3
    } t_op;

    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIT     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISS    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EVICTED = 3'd6;
    localparam logic [STATUS_W-1:0] ST_NONE    = 3'd7;

    typedef struct packed {
        t_op                 opcode;
        logic [TAG_W-1:0]    lookup_tag;
        logic [HANDLE_W-1:0] picture_handle;
        logic [SIZE_W-1:0]   picture_bytes;
        logic                bypass_flag;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TAG_W-1:0]    tag_out;
        logic [HANDLE_W-1:0] handle_out;
        logic                bypass_out;
        logic [BYTES_W-1:0]  bytes_total;
        logic [ENTRY_W-1:0]  count_total;
        logic                last;
    } t_out;

    typedef struct packed {
        logic tag;
        logic handle;
        logic bytes;
        logic bypass;
        logic serial;
    } t_mem_we;

endpackage

// ----- design/lcb_alu.sv -----
module lcb_alu
    import lcb_pkg::*;
(
    input  logic [SERIAL_W-1:0] i_a,
    input  logic [SERIAL_W-1:0] i_b,
    input  logic                i_sub,
    output logic [SERIAL_W-1:0] o_sum,
    output logic                o_lt
);

    logic [SERIAL_W:0] w_full;
    logic [SERIAL_W-1:0] w_b;

    assign w_b    = i_sub ? ~i_b : i_b;
    assign w_full = {1'b0, i_a} + {1'b0, w_b} + (SERIAL_W+1)'(i_sub);
    assign o_sum  = w_full[SERIAL_W-1:0];
    // a < b unsigned when subtracting gives no carry out
    assign o_lt   = i_sub & ~w_full[SERIAL_W];

endmodule

// ----- design/lcb_slot_mem.sv -----
module lcb_slot_mem
    import lcb_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic                        i_clk,
    input  t_mem_we                     i_we,
    input  logic [$clog2(SLOTS)-1:0]    i_waddr,
    input  logic [TAG_W-1:0]            i_wtag,
    input  logic [HANDLE_W-1:0]         i_whandle,
    input  logic [SIZE_W-1:0]           i_wbytes,
    input  logic                        i_wbypass,
    input  logic [SERIAL_W-1:0]         i_wserial,
    input  logic [$clog2(SLOTS)-1:0]    i_raddr,
    output logic [TAG_W-1:0]            o_rtag,
    output logic [HANDLE_W-1:0]         o_rhandle,
    output logic [SIZE_W-1:0]           o_rbytes,
    output logic                        o_rbypass,
    output logic [SERIAL_W-1:0]         o_rserial
);

    logic [TAG_W-1:0]    r_tag_mem    [SLOTS];
    logic [HANDLE_W-1:0] r_handle_mem [SLOTS];
    logic [SIZE_W-1:0]   r_bytes_mem  [SLOTS];
    logic                r_bypass_mem [SLOTS];
    logic [SERIAL_W-1:0] r_serial_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_we.tag) begin
            r_tag_mem[i_waddr] <= i_wtag;
        end
        if (i_we.handle) begin
            r_handle_mem[i_waddr] <= i_whandle;
        end
        if (i_we.bytes) begin
            r_bytes_mem[i_waddr] <= i_wbytes;
        end
        if (i_we.bypass) begin
            r_bypass_mem[i_waddr] <= i_wbypass;
        end
        if (i_we.serial) begin
            r_serial_mem[i_waddr] <= i_wserial;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rtag    <= r_tag_mem[i_raddr];
        o_rhandle <= r_handle_mem[i_raddr];
        o_rbytes  <= r_bytes_mem[i_raddr];
        o_rbypass <= r_bypass_mem[i_raddr];
        o_rserial <= r_serial_mem[i_raddr];
    end

endmodule

// ----- design/lru_cache_byte_and_count_budget_unit.sv -----
// Fully associative LRU table of SLOTS entries with a byte budget and an entry
// budget. A command transaction (add, remove, lookup) scans every slot through
// the single read port of the slot memory, one slot per cycle, then uses the
// shared 64-bit adder/comparator to update the byte total and the touch serial
// as the command needs. A prune rescans the table for the lowest serial on
// every eviction. Input stall is high whenever a transaction is in progress;
// one result register sits on the output, so a finished result may wait there
// while the next transaction runs.
module lru_cache_byte_and_count_budget_unit
    import lcb_pkg::*;
#(
    parameter int SLOTS = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int KW = (CW > ENTRY_W) ? CW : ENTRY_W;
    localparam logic [IW:0] SCAN_END = (IW+1)'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SUB,
        S_BADD,
        S_INC,
        S_EMIT,
        S_PCHK
    } t_state;

    t_state               r_state;
    t_in                  r_in;
    logic [SLOTS-1:0]     r_valid;
    logic [CW-1:0]        r_count;
    logic [BYTES_W-1:0]   r_sum;
    logic [SERIAL_W-1:0]  r_ctr;
    logic [BYTES_W-1:0]   r_byte_budget;
    logic [ENTRY_W-1:0]   r_entry_budget;
    logic [IW:0]          r_cnt;
    logic                 r_found;
    logic                 r_free_found;
    logic [IW-1:0]        r_free_idx;
    logic [IW-1:0]        r_sel_idx;
    logic [TAG_W-1:0]     r_sel_tag;
    logic [HANDLE_W-1:0]  r_sel_handle;
    logic [SIZE_W-1:0]    r_sel_bytes;
    logic                 r_sel_byp;
    logic [SERIAL_W-1:0]  r_sel_serial;
    logic                 r_pend;
    logic [STATUS_W-1:0]  r_status;
    t_out                 r_out;
    logic                 r_out_vld;

    logic [TAG_W-1:0]     rd_tag;
    logic [HANDLE_W-1:0]  rd_handle;
    logic [SIZE_W-1:0]    rd_bytes;
    logic                 rd_byp;
    logic [SERIAL_W-1:0]  rd_serial;

    logic [SERIAL_W-1:0]  alu_a;
    logic [SERIAL_W-1:0]  alu_b;
    logic                 alu_sub;
    logic [SERIAL_W-1:0]  alu_sum;
    logic                 alu_lt;

    t_mem_we              mem_we;
    logic [IW:0]          p_full;
    logic [IW-1:0]        p_idx;
    logic                 p_vld;
    logic                 out_free;
    logic                 out_load;
    logic                 count_gt;
    logic                 cont;
    logic [STATUS_W-1:0]  em_status;
    logic                 em_last;
    t_out                 em;

    lcb_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum),
        .o_lt  (alu_lt)
    );

    lcb_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_sel_idx),
        .i_wtag    (r_in.lookup_tag),
        .i_whandle (r_in.picture_handle),
        .i_wbytes  (r_in.picture_bytes),
        .i_wbypass (r_in.bypass_flag),
        .i_wserial (alu_sum),
        .i_raddr   (r_cnt[IW-1:0]),
        .o_rtag    (rd_tag),
        .o_rhandle (rd_handle),
        .o_rbytes  (rd_bytes),
        .o_rbypass (rd_byp),
        .o_rserial (rd_serial)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = r_out_vld;
    assign o_data   = r_out;
    assign out_free = !r_out_vld || !i_stall;
    assign out_load = out_free && ((r_state == S_EMIT) ||
                                   (r_state == S_PCHK && (r_pend || !cont)));

    assign p_full   = r_cnt - (IW+1)'(1);
    assign p_idx    = p_full[IW-1:0];
    assign p_vld    = r_valid[p_idx];
    assign count_gt = KW'(r_count) > KW'(r_entry_budget);
    assign cont     = (alu_lt || count_gt) && (|r_valid);

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_SCAN: begin
                alu_a   = rd_serial;
                alu_b   = r_sel_serial;
                alu_sub = 1'b1;
            end
            S_PCHK: begin
                alu_a   = SERIAL_W'(r_byte_budget);
                alu_b   = SERIAL_W'(r_sum);
                alu_sub = 1'b1;
            end
            S_SUB: begin
                alu_a   = SERIAL_W'(r_sum);
                alu_b   = SERIAL_W'(r_sel_bytes);
                alu_sub = 1'b1;
            end
            S_BADD: begin
                alu_a = SERIAL_W'(r_sum);
                alu_b = SERIAL_W'(r_in.picture_bytes);
            end
            S_INC: begin
                alu_a = r_ctr;
                alu_b = SERIAL_W'(1);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        mem_we = '0;
        if (r_state == S_INC) begin
            mem_we.serial = 1'b1;
            if (r_in.opcode == OP_ADD) begin
                mem_we.tag    = 1'b1;
                mem_we.handle = 1'b1;
                mem_we.bytes  = 1'b1;
                mem_we.bypass = 1'b1;
            end
        end
    end

    always_comb begin
        if (r_state == S_PCHK) begin
            em_status = r_pend ? ST_EVICTED : ST_NONE;
            em_last   = !(r_pend && cont);
        end else begin
            em_status = r_status;
            em_last   = 1'b1;
        end
        em.status      = em_status;
        em.tag_out     = (em_status == ST_HIT || em_status == ST_EVICTED) ? r_sel_tag : '0;
        em.handle_out  = (em_status == ST_HIT || em_status == ST_EVICTED) ? r_sel_handle : '0;
        em.bypass_out  = (em_status == ST_HIT) ? r_sel_byp : 1'b0;
        em.bytes_total = r_sum;
        em.count_total = ENTRY_W'(r_count);
        em.last        = em_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_valid        <= '0;
            r_count        <= '0;
            r_sum          <= '0;
            r_ctr          <= '0;
            r_byte_budget  <= BYTE_BUDGET_RST;
            r_entry_budget <= ENTRY_BUDGET_RST;
            r_out_vld      <= 1'b0;
            r_pend         <= 1'b0;
            r_found        <= 1'b0;
            r_free_found   <= 1'b0;
            r_cnt          <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BYTE_BUDGET:  r_byte_budget  <= i_cfg_data[BYTES_W-1:0];
                    CFG_ENTRY_BUDGET: r_entry_budget <= i_cfg_data[ENTRY_W-1:0];
                endcase
            end

            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && !i_stall) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in         <= i_data;
                        r_cnt        <= '0;
                        r_found      <= 1'b0;
                        r_free_found <= 1'b0;
                        r_pend       <= 1'b0;
                        r_state      <= (i_data.opcode == OP_PRUNE) ? S_PCHK : S_SCAN;
                    end
                end

                S_SCAN: begin
                    if (r_cnt != '0) begin
                        if (r_in.opcode == OP_PRUNE) begin
                            // lowest serial wins, ties to the lowest slot
                            if (p_vld && (!r_found || alu_lt)) begin
                                r_found      <= 1'b1;
                                r_sel_idx    <= p_idx;
                                r_sel_serial <= rd_serial;
                                r_sel_tag    <= rd_tag;
                                r_sel_handle <= rd_handle;
                                r_sel_bytes  <= rd_bytes;
                            end
                        end else begin
                            if (p_vld && !r_found && rd_tag == r_in.lookup_tag) begin
                                r_found      <= 1'b1;
                                r_sel_idx    <= p_idx;
                                r_sel_tag    <= rd_tag;
                                r_sel_handle <= rd_handle;
                                r_sel_bytes  <= rd_bytes;
                                r_sel_byp    <= rd_byp;
                            end
                            if (!p_vld && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free_idx   <= p_idx;
                            end
                        end
                    end
                    if (r_cnt == SCAN_END) begin
                        r_state <= (r_in.opcode == OP_PRUNE) ? S_SUB : S_DECIDE;
                    end else begin
                        r_cnt <= r_cnt + (IW+1)'(1);
                    end
                end

                S_DECIDE: begin
                    unique case (r_in.opcode)
                        OP_ADD: begin
                            if (r_found) begin
                                r_state <= S_SUB;
                            end else if (r_free_found) begin
                                r_sel_idx           <= r_free_idx;
                                r_valid[r_free_idx] <= 1'b1;
                                r_count             <= r_count + CW'(1);
                                r_state             <= S_BADD;
                            end else begin
                                r_status <= ST_FULL;
                                r_state  <= S_EMIT;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_found) begin
                                r_state <= S_SUB;
                            end else begin
                                r_status <= ST_ABSENT;
                                r_state  <= S_EMIT;
                            end
                        end
                        OP_LOOKUP: begin
                            if (r_found) begin
                                r_state <= S_INC;
                            end else begin
                                r_status <= ST_MISS;
                                r_state  <= S_EMIT;
                            end
                        end
                        OP_PRUNE: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end

                S_SUB: begin
                    r_sum <= alu_sum[BYTES_W-1:0];
                    unique case (r_in.opcode)
                        OP_ADD: begin
                            r_state <= S_BADD;
                        end
                        OP_REMOVE: begin
                            r_valid[r_sel_idx] <= 1'b0;
                            r_count            <= r_count - CW'(1);
                            r_status           <= ST_REMOVED;
                            r_state            <= S_EMIT;
                        end
                        OP_PRUNE: begin
                            r_valid[r_sel_idx] <= 1'b0;
                            r_count            <= r_count - CW'(1);
                            r_pend             <= 1'b1;
                            r_state            <= S_PCHK;
                        end
                        OP_LOOKUP: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end

                S_BADD: begin
                    r_sum   <= alu_sum[BYTES_W-1:0];
                    r_state <= S_INC;
                end

                S_INC: begin
                    r_ctr    <= alu_sum;
                    r_status <= (r_in.opcode == OP_ADD) ? ST_ADDED : ST_HIT;
                    r_state  <= S_EMIT;
                end

                S_EMIT: begin
                    if (out_free) begin
                        r_out   <= em;
                        r_state <= S_IDLE;
                    end
                end

                S_PCHK: begin
                    if (r_pend) begin
                        if (out_free) begin
                            r_out <= em;
                            if (cont) begin
                                r_cnt   <= '0;
                                r_found <= 1'b0;
                                r_state <= S_SCAN;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    end else if (cont) begin
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else if (out_free) begin
                        r_out   <= em;
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/lcb_checker.sv -----
`include "lru_cache_byte_and_count_budget_unit_macros.svh"

module lcb_checker
    import lcb_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    `LCB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

    `LCB_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    `LCB_ASSERT_NOW(a_single_result_last, i_clk, i_rst_n, o_valid && o_data.status != ST_EVICTED, o_data.last)

    `LCB_ASSERT_NOW(a_payload_zero, i_clk, i_rst_n, o_valid && o_data.status != ST_HIT && o_data.status != ST_EVICTED, o_data.tag_out == '0 && o_data.handle_out == '0 && !o_data.bypass_out)

endmodule

bind lru_cache_byte_and_count_budget_unit lcb_checker u_lcb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
